/* rtl/wbd_pkg.sv */
// Shared classes, result types and word-break rule functions.
package wbd_pkg;

  localparam logic [4:0] C_OTHER = 5'd0;
  localparam logic [4:0] C_CR    = 5'd1;
  localparam logic [4:0] C_LF    = 5'd2;
  localparam logic [4:0] C_NL    = 5'd3;
  localparam logic [4:0] C_EXT   = 5'd4;
  localparam logic [4:0] C_FMT   = 5'd5;
  localparam logic [4:0] C_KATA  = 5'd6;
  localparam logic [4:0] C_AL    = 5'd7;
  localparam logic [4:0] C_HL    = 5'd8;
  localparam logic [4:0] C_ML    = 5'd9;
  localparam logic [4:0] C_MNL   = 5'd10;
  localparam logic [4:0] C_SQ    = 5'd11;
  localparam logic [4:0] C_DQ    = 5'd12;
  localparam logic [4:0] C_NUM   = 5'd13;
  localparam logic [4:0] C_ENL   = 5'd14;
  localparam logic [4:0] C_RI    = 5'd15;
  localparam logic [4:0] C_MN    = 5'd16;

  localparam int MAX_RES = 3;

  typedef struct packed {
    logic [31:0] position;
    logic        is_break;
  } result_t;

  // One queue entry: all results caused by one item, slot 0 first.
  typedef struct packed {
    logic [1:0]               cnt;
    result_t [MAX_RES-1:0]    res;
  } entry_t;

  function automatic logic is_ign(input logic [4:0] c);
    return (c == C_EXT) || (c == C_FMT);
  endfunction

  function automatic logic is_nl(input logic [4:0] c);
    return (c == C_CR) || (c == C_LF) || (c == C_NL);
  endfunction

  function automatic logic is_let(input logic [4:0] c);
    return (c == C_AL) || (c == C_HL);
  endfunction

  function automatic logic is_aln(input logic [4:0] c);
    return is_let(c) || (c == C_NUM);
  endfunction

  function automatic logic is_midlet(input logic [4:0] c);
    return (c == C_ML) || (c == C_MNL) || (c == C_SQ);
  endfunction

  function automatic logic is_midnum(input logic [4:0] c);
    return (c == C_MN) || (c == C_MNL) || (c == C_SQ);
  endfunction

  function automatic logic needs_next(input logic [4:0] a, input logic [4:0] b);
    return (is_let(a) && is_midlet(b)) || ((a == C_HL) && (b == C_DQ)) ||
           ((a == C_NUM) && is_midnum(b));
  endfunction

  // Rules from WB5 on: a|b is the position, d before a (if dp), c after b (if cp).
  function automatic logic decide(input logic [4:0] a, input logic [4:0] b,
                                  input logic dp, input logic [4:0] d,
                                  input logic cp, input logic [4:0] c);
    logic brk;
    brk = 1'b1;
    if (is_aln(a) && is_aln(b)) brk = 1'b0;
    else if ((a == C_HL) && (b == C_SQ)) brk = 1'b0;
    else if (cp && ((is_let(a) && is_midlet(b) && is_let(c)) ||
                    ((a == C_HL) && (b == C_DQ) && (c == C_HL)))) brk = 1'b0;
    else if (dp && ((is_let(d) && is_midlet(a) && is_let(b)) ||
                    ((d == C_HL) && (a == C_DQ) && (b == C_HL)))) brk = 1'b0;
    else if (cp && (a == C_NUM) && is_midnum(b) && (c == C_NUM)) brk = 1'b0;
    else if (dp && (d == C_NUM) && is_midnum(a) && (b == C_NUM)) brk = 1'b0;
    else if ((a == C_KATA) && (b == C_KATA)) brk = 1'b0;
    else if ((b == C_ENL) && (is_aln(a) || (a == C_KATA) || (a == C_ENL))) brk = 1'b0;
    else if ((a == C_ENL) && (is_aln(b) || (b == C_KATA))) brk = 1'b0;
    else if ((a == C_RI) && (b == C_RI)) brk = 1'b0;
    return brk;
  endfunction

endpackage

/* rtl/wbd_front.sv */
// Front end: accepts classes, applies the break rules, emits at most one entry per item.
module wbd_front import wbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [4:0]  in_class,
  input  logic        in_eot,
  output logic        in_ready,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_entry
);

  logic [4:0]  raw_prev_class;
  logic [4:0]  last_real_class;
  logic [4:0]  before_last_class;
  logic [1:0]  real_count;
  logic [31:0] position_counter;
  logic        pending_valid;
  logic [31:0] pending_position;
  logic [4:0]  pending_left;
  logic [4:0]  pending_right;
  logic [5:0]  pending_before_left;
  logic        text_open;

  logic [4:0]  cls;
  logic        ign;
  logic        accept;
  logic        res_pend;
  logic        pend_brk;
  logic        own_brk;
  logic        defer;
  logic [1:0]  n;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign push     = accept && (n != 2'd0);

  always_comb begin
    cls      = (in_class > C_MN) ? C_OTHER : in_class;
    ign      = is_ign(cls);
    res_pend = pending_valid && (!ign || in_eot);
    pend_brk = decide(pending_left, pending_right, !pending_before_left[5],
                      pending_before_left[4:0], !ign, cls);
    own_brk  = 1'b1;
    defer    = 1'b0;
    if (!text_open) begin
      own_brk = 1'b1;
    end else if ((raw_prev_class == C_CR) && (cls == C_LF)) begin
      own_brk = 1'b0;
    end else if (is_nl(raw_prev_class) || is_nl(cls)) begin
      own_brk = 1'b1;
    end else if (ign || (real_count == 2'd0)) begin
      own_brk = 1'b0;
    end else begin
      own_brk = decide(last_real_class, cls, real_count[1], before_last_class,
                       1'b0, C_OTHER);
      defer   = own_brk && !in_eot && needs_next(last_real_class, cls);
    end

    // Results in order: resolved pending, this position, end of text.
    push_entry = '0;
    n          = 2'd0;
    if (res_pend) begin
      push_entry.res[n] = '{position: pending_position, is_break: pend_brk};
      n = n + 2'd1;
    end
    if (!defer) begin
      push_entry.res[n] = '{position: position_counter, is_break: own_brk};
      n = n + 2'd1;
    end
    if (in_eot) begin
      push_entry.res[n] = '{position: position_counter + 32'd1, is_break: 1'b1};
      n = n + 2'd1;
    end
    push_entry.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_prev_class      <= C_OTHER;
      last_real_class     <= C_OTHER;
      before_last_class   <= C_OTHER;
      real_count          <= 2'd0;
      position_counter    <= 32'd0;
      pending_valid       <= 1'b0;
      pending_position    <= 32'd0;
      pending_left        <= C_OTHER;
      pending_right       <= C_OTHER;
      pending_before_left <= 6'd0;
      text_open           <= 1'b0;
    end else if (accept) begin
      // defer never happens on end of text
      if (defer) begin
        pending_valid       <= 1'b1;
        pending_position    <= position_counter;
        pending_left        <= last_real_class;
        pending_right       <= cls;
        pending_before_left <= real_count[1] ? {1'b0, before_last_class} : 6'b100000;
      end else if (res_pend || in_eot) begin
        pending_valid <= 1'b0;
      end
      if (in_eot) begin
        raw_prev_class    <= C_OTHER;
        last_real_class   <= C_OTHER;
        before_last_class <= C_OTHER;
        real_count        <= 2'd0;
        position_counter  <= 32'd0;
        text_open         <= 1'b0;
      end else begin
        raw_prev_class <= cls;
        if (!ign) begin
          before_last_class <= last_real_class;
          last_real_class   <= cls;
          if (!real_count[1]) real_count <= real_count + 2'd1;
        end
        position_counter <= position_counter + 32'd1;
        text_open        <= 1'b1;
      end
    end
  end

endmodule

/* rtl/wbd_queue.sv */
// Small entry queue between front and back ends.
module wbd_queue import wbd_pkg::*; #(
  parameter int DEPTH = 4
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   empty,
  output entry_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t        mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop)      count <= count + CW'(1);
      else if (pop && !push) count <= count - CW'(1);
    end
  end

endmodule

/* rtl/wbd_back.sv */
// Back end: walks the results of the head entry out one per cycle while out_ready is high.
module wbd_back import wbd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res,
  output logic        out_last
);

  logic [1:0] sub;

  assign out_valid = !empty;
  assign out_res   = head.res[sub];
  assign out_last  = (sub == head.cnt - 2'd1);
  assign pop       = out_valid && out_ready && out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      sub <= 2'd0;
    end else if (out_valid && out_ready) begin
      sub <= out_last ? 2'd0 : sub + 2'd1;
    end
  end

endmodule

/* rtl/word_boundary_detector.sv */
// Word boundary detector: word-break classes in, positioned boundary decisions out.
// An item's results enter the queue when it is accepted; held decisions wait for the
// next non-ignored class or end of text. Throughput: one item per cycle unless the queue
// is full; results leave one per cycle while m_tready is high, and the QUEUE_DEPTH-entry
// queue absorbs items with two or three results. Reset (rst, synchronous): history,
// pending decision, position counter and queue are cleared; next item starts a new text.
module word_boundary_detector import wbd_pkg::*; #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [4:0] word_class, [7:5] zero
  input  logic        s_tlast,   // end_of_text
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] position, [32] is_break, [39:33] zero
  output logic        m_tlast    // last
);

  logic    q_full;
  logic    q_empty;
  logic    push;
  logic    pop;
  entry_t  push_entry;
  entry_t  head;
  result_t out_res;

  wbd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_class   (s_tdata[4:0]),
    .in_eot     (s_tlast),
    .in_ready   (s_tready),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  wbd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .empty      (q_empty),
    .head       (head)
  );

  wbd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_res    (out_res),
    .out_last   (m_tlast)
  );

  assign m_tdata = {7'd0, out_res.is_break, out_res.position};

  // end of text always yields at least the end-position result
  assert property (@(posedge clk) disable iff (rst)
    push && s_tlast |-> push_entry.cnt != 2'd0 && push_entry.res[push_entry.cnt - 2'd1].is_break)
    else $error("end of text entry lacks a closing break");

  // a queued entry never carries zero results
  assert property (@(posedge clk) disable iff (rst) !q_empty |-> head.cnt != 2'd0)
    else $error("empty entry at queue head");

  // queue cannot be full and empty at once
  assert property (@(posedge clk) disable iff (rst) !(q_full && q_empty))
    else $error("queue full and empty together");

endmodule
